### src/sbt_pkg.sv
// Shared types and constants for the sorted breakpoint table.
// Used by the entry memory, the sequencer and the top level; depends on nothing.
package sbt_pkg;

    localparam int DEFAULT_TABLE_DEPTH = 32;

    localparam logic OP_ADD    = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;
    localparam logic [1:0] ST_FAULT   = 2'd3;

    localparam logic [2:0] SIZE_NONE  = 3'd0;
    localparam logic [2:0] SIZE_THUMB = 3'd2;
    localparam logic [2:0] SIZE_ARM   = 3'd4;

    localparam logic [31:0] BKPT_ARM   = 32'hEF00_00FF;
    localparam logic [31:0] BKPT_THUMB = 32'h0000_DFFF;

    typedef struct packed {
        logic        opcode;
        logic [31:0] address;
        logic        thumb;
        logic        persist;
        logic [31:0] original_word;
        logic        mem_ok;
    } req_t;

    typedef struct packed {
        logic [31:0] address;
        logic [31:0] saved_word;
        logic [2:0]  size;
        logic        persistent;
    } entry_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [5:0]  slot;
        logic [31:0] patch_word;
        logic [2:0]  patch_size;
        logic [5:0]  entry_count;
    } res_t;

endpackage

### src/sbt_mem.sv
// Entry memory of the breakpoint table: one write port and one registered read port.
// Depends on sbt_pkg for the entry type.
module sbt_mem #(
    parameter int DEPTH = sbt_pkg::DEFAULT_TABLE_DEPTH,
    parameter int IDX_W = 5
) (
    input  logic               clk,
    input  logic               we,
    input  logic [IDX_W-1:0]   waddr,
    input  sbt_pkg::entry_t    wdata,
    input  logic               re,
    input  logic [IDX_W-1:0]   raddr,
    output sbt_pkg::entry_t    rdata
);

    sbt_pkg::entry_t mem [DEPTH];
    sbt_pkg::entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### src/sbt_ctrl.sv
// Sequencer of the breakpoint table: binary search, request checks and entry shifting.
// Depends on sbt_pkg; drives the ports of sbt_mem.
module sbt_ctrl #(
    parameter int DEPTH = sbt_pkg::DEFAULT_TABLE_DEPTH,
    parameter int IDX_W = 5,
    parameter int CNT_W = 6
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    input  sbt_pkg::req_t      req_in,
    output logic               busy,
    output logic               res_valid,
    output sbt_pkg::res_t      res,
    input  logic               res_ack,
    output logic               mem_we,
    output logic [IDX_W-1:0]   mem_waddr,
    output sbt_pkg::entry_t    mem_wdata,
    output logic               mem_re,
    output logic [IDX_W-1:0]   mem_raddr,
    input  sbt_pkg::entry_t    mem_rdata
);

    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_SRD     = 8'b0000_0010,
        S_SCMP    = 8'b0000_0100,
        S_CHECK   = 8'b0000_1000,
        S_INS     = 8'b0001_0000,
        S_INS_NEW = 8'b0010_0000,
        S_DEL     = 8'b0100_0000,
        S_DONE    = 8'b1000_0000
    } state_t;

    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

    state_t              state_reg, state_next;
    sbt_pkg::req_t       req_reg, req_next;
    logic [CNT_W-1:0]    lo_reg, lo_next;
    logic [CNT_W-1:0]    hi_reg, hi_next;
    logic [CNT_W-1:0]    ptr_reg, ptr_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [1:0]          status_reg, status_next;
    logic [31:0]         pword_reg, pword_next;
    logic [2:0]          psize_reg, psize_next;
    logic                wpend_reg, wpend_next;
    logic [IDX_W-1:0]    widx_reg, widx_next;

    logic [CNT_W-1:0]    mid;
    logic [CNT_W-1:0]    ptr_dec;
    logic [CNT_W-1:0]    ptr_inc;
    logic                hit;
    logic                misaligned;
    sbt_pkg::entry_t     new_entry;

    assign mid     = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign ptr_dec = ptr_reg - CNT_W'(1);
    assign ptr_inc = ptr_reg + CNT_W'(1);
    assign hit     = (lo_reg < count_reg) && (mem_rdata.address == req_reg.address);
    assign misaligned = req_reg.thumb ? req_reg.address[0] : (req_reg.address[1:0] != 2'b00);

    always_comb
    begin
        new_entry.address    = req_reg.address;
        new_entry.saved_word = req_reg.thumb ? {16'h0000, req_reg.original_word[15:0]}
                                             : req_reg.original_word;
        new_entry.size       = req_reg.thumb ? sbt_pkg::SIZE_THUMB : sbt_pkg::SIZE_ARM;
        new_entry.persistent = req_reg.persist;
    end

    always_comb
    begin
        state_next  = state_reg;
        req_next    = req_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        ptr_next    = ptr_reg;
        count_next  = count_reg;
        status_next = status_reg;
        pword_next  = pword_reg;
        psize_next  = psize_reg;
        wpend_next  = 1'b0;
        widx_next   = widx_reg;
        mem_re      = 1'b0;
        mem_raddr   = '0;
        mem_we      = 1'b0;
        mem_waddr   = widx_reg;
        mem_wdata   = mem_rdata;
        res_valid   = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    req_next   = req_in;
                    lo_next    = '0;
                    hi_next    = count_reg;
                    state_next = S_SRD;
                end
            end
            S_SRD:
            begin
                mem_re = 1'b1;
                if (lo_reg < hi_reg)
                begin
                    mem_raddr  = mid[IDX_W-1:0];
                    state_next = S_SCMP;
                end
                else
                begin
                    mem_raddr  = lo_reg[IDX_W-1:0];
                    state_next = S_CHECK;
                end
            end
            S_SCMP:
            begin
                if (mem_rdata.address < req_reg.address)
                begin
                    lo_next = mid + CNT_W'(1);
                end
                else
                begin
                    hi_next = mid;
                end
                state_next = S_SRD;
            end
            S_CHECK:
            begin
                status_next = sbt_pkg::ST_OK;
                pword_next  = '0;
                psize_next  = sbt_pkg::SIZE_NONE;
                state_next  = S_DONE;
                if (req_reg.opcode == sbt_pkg::OP_ADD)
                begin
                    if (hit)
                    begin
                        status_next = sbt_pkg::ST_OK;
                    end
                    else if (count_reg >= DEPTH_C)
                    begin
                        status_next = sbt_pkg::ST_FULL;
                    end
                    else if (misaligned)
                    begin
                        status_next = sbt_pkg::ST_INVALID;
                    end
                    else if (!req_reg.mem_ok)
                    begin
                        status_next = sbt_pkg::ST_FAULT;
                    end
                    else
                    begin
                        pword_next = req_reg.thumb ? sbt_pkg::BKPT_THUMB : sbt_pkg::BKPT_ARM;
                        psize_next = new_entry.size;
                        ptr_next   = count_reg;
                        state_next = S_INS;
                    end
                end
                else
                begin
                    if (!hit)
                    begin
                        status_next = sbt_pkg::ST_INVALID;
                    end
                    else if (!req_reg.mem_ok)
                    begin
                        status_next = sbt_pkg::ST_FAULT;
                    end
                    else
                    begin
                        pword_next = mem_rdata.saved_word;
                        psize_next = mem_rdata.size;
                        ptr_next   = lo_reg;
                        state_next = S_DEL;
                    end
                end
            end
            S_INS:
            begin
                mem_we = wpend_reg;
                if (ptr_reg > lo_reg)
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = ptr_dec[IDX_W-1:0];
                    wpend_next = 1'b1;
                    widx_next  = ptr_reg[IDX_W-1:0];
                    ptr_next   = ptr_dec;
                end
                else
                begin
                    state_next = S_INS_NEW;
                end
            end
            S_INS_NEW:
            begin
                mem_we     = 1'b1;
                mem_waddr  = lo_reg[IDX_W-1:0];
                mem_wdata  = new_entry;
                count_next = count_reg + CNT_W'(1);
                state_next = S_DONE;
            end
            S_DEL:
            begin
                mem_we = wpend_reg;
                if (ptr_inc < count_reg)
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = ptr_inc[IDX_W-1:0];
                    wpend_next = 1'b1;
                    widx_next  = ptr_reg[IDX_W-1:0];
                    ptr_next   = ptr_inc;
                end
                else
                begin
                    count_next = count_reg - CNT_W'(1);
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                res_valid = 1'b1;
                if (res_ack)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            lo_reg    <= '0;
            hi_reg    <= '0;
            ptr_reg   <= '0;
            wpend_reg <= 1'b0;
            widx_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            lo_reg    <= lo_next;
            hi_reg    <= hi_next;
            ptr_reg   <= ptr_next;
            wpend_reg <= wpend_next;
            widx_reg  <= widx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        status_reg <= status_next;
        pword_reg  <= pword_next;
        psize_reg  <= psize_next;
    end

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        res.status      = status_reg;
        res.slot        = 6'(lo_reg);
        res.patch_word  = pword_reg;
        res.patch_size  = psize_reg;
        res.entry_count = 6'(count_reg);
    end

endmodule

### src/sorted_breakpoint_table_core.sv
// Sorted breakpoint table: add and remove requests with binary search over one entry memory.
// Each search step reads the entry memory and compares the registered read data with the address.
// Entries are moved one at a time, each read from the memory and written back one slot over.
// One transaction at a time; the next is taken while the last result waits at the output.
// Reset empties the table at once by clearing the entry count; the memory is not swept.
module sorted_breakpoint_table_core #(
    parameter int TABLE_DEPTH = sbt_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        opcode,
    input  logic [31:0] address,
    input  logic        thumb,
    input  logic        persist,
    input  logic [31:0] original_word,
    input  logic        mem_ok,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [5:0]  slot,
    output logic [31:0] patch_word,
    output logic [2:0]  patch_size,
    output logic [5:0]  entry_count
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    sbt_pkg::req_t    req;
    sbt_pkg::res_t    res;
    sbt_pkg::res_t    res_data_reg;
    logic             res_valid;
    logic             res_load;
    logic             out_valid_reg, out_valid_next;
    logic             busy;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    sbt_pkg::entry_t  mem_wdata;
    logic             mem_re;
    logic [IDX_W-1:0] mem_raddr;
    sbt_pkg::entry_t  mem_rdata;

    always_comb
    begin
        req.opcode        = opcode;
        req.address       = address;
        req.thumb         = thumb;
        req.persist       = persist;
        req.original_word = original_word;
        req.mem_ok        = mem_ok;
    end

    sbt_ctrl #(
        .DEPTH (TABLE_DEPTH),
        .IDX_W (IDX_W),
        .CNT_W (CNT_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (in_valid),
        .req_in    (req),
        .busy      (busy),
        .res_valid (res_valid),
        .res       (res),
        .res_ack   (res_load),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    sbt_mem #(
        .DEPTH (TABLE_DEPTH),
        .IDX_W (IDX_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign in_stall = busy;
    assign res_load = res_valid && (!out_valid_reg || !out_stall);

    always_comb
    begin
        if (res_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_stall)
        begin
            out_valid_next = out_valid_reg;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_data_reg <= res;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = res_data_reg.status;
    assign slot        = res_data_reg.slot;
    assign patch_word  = res_data_reg.patch_word;
    assign patch_size  = res_data_reg.patch_size;
    assign entry_count = res_data_reg.entry_count;

endmodule
